// ===== rtl/spl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and constants for the sorted priority list unit.
// ----------------------------------------------------------------------------
package spl_pkg;

   // number of cells in the list
   localparam int CAPACITY = 16;

   // width of the internal entry counter (holds 0 .. CAPACITY)
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // width of the entry count field on the result channel
   localparam int COUNT_OUT_W = 5;

   // action codes
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_POP    = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef logic signed [31:0] data_type;

   // command broadcast to every cell
   typedef struct packed {
      logic     insert;
      logic     pop;
      data_type value;
   } cell_cmd_type;

endpackage : spl_pkg
`default_nettype wire

// ===== rtl/sorted_priority_list_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_list_unit
// Bounded ascending list of signed values built as a chain of cells; insert
// places a value in sorted order, pop removes the smallest.
// ----------------------------------------------------------------------------
// result: an accepted request's result is in the output register in the cycle after it is accepted
// throughput: 1 request per cycle while req_stall is low; every cell compares and shifts in the same cycle
// the output register takes a new result whenever the old one is taken or absent
// reset: clears all cell valid bits, the entry count and the output valid
// ----------------------------------------------------------------------------
module sorted_priority_list_unit
   import spl_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_action,
   input  wire logic signed [31:0]      req_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [31:0]           rsp_popped_value,
   output logic [1:0]                   rsp_status,
   output logic [COUNT_OUT_W-1:0]       rsp_entry_count
);

   data_type     cell_value [CAPACITY];
   logic         cell_valid [CAPACITY];
   logic         cell_place [CAPACITY];
   cell_cmd_type cmd;

   logic         req_accept;
   logic         list_empty;
   logic         list_full;
   logic         is_pop;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   data_type         popped_ff, popped_in;
   status_type       status_ff, status_in;

   // handshake: output register frees up when its result is taken
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign list_empty = !cell_valid[0];
   assign list_full  = cell_valid[CAPACITY-1];
   assign is_pop     = (req_action == ACTION_POP);

   // decode request into cell command and result
   always_comb begin
      cmd.insert = 1'b0;
      cmd.pop    = 1'b0;
      cmd.value  = req_value;
      popped_in  = '0;
      status_in  = STATUS_OK;
      count_in   = count_ff;
      if (is_pop) begin
         if (list_empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            cmd.pop   = req_accept;
            popped_in = cell_value[0];
            count_in  = count_ff - CNT_W'(1);
         end
      end else begin
         if (list_full) begin
            status_in = STATUS_FULL;
         end else begin
            cmd.insert = req_accept;
            count_in   = count_ff + CNT_W'(1);
         end
      end
   end

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type left_value;
      logic     left_valid;
      logic     left_place;
      data_type right_value;
      logic     right_valid;

      if (i == 0) begin : g_head
         assign left_value = '0;
         assign left_valid = 1'b1;
         assign left_place = 1'b0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_place = cell_place[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      spl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .left_place  (left_place),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .place       (cell_place[i])
      );
   end

   // control state: count and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   logic [CNT_W-1:0] count_rsp_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         popped_ff    <= popped_in;
         status_ff    <= status_in;
         count_rsp_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = COUNT_OUT_W'(count_rsp_ff);

endmodule : sorted_priority_list_unit
`default_nettype wire

// ===== rtl/spl_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spl_cell
// One slot of the sorted list: holds a value and a valid bit, compares the
// broadcast value and shifts with its neighbors on insert or pop.
// ----------------------------------------------------------------------------
module spl_cell
   import spl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   // neighbor toward the head (smaller values)
   input  wire data_type     left_value,
   input  wire logic         left_valid,
   input  wire logic         left_place,
   // neighbor toward the tail (larger values)
   input  wire data_type     right_value,
   input  wire logic         right_valid,
   output data_type          value,
   output logic              valid,
   output logic              place
);

   data_type value_ff, value_in;
   logic     valid_ff, valid_in;

   // new value belongs at or before this slot (ahead of equal values)
   assign place = !valid_ff || (cmd.value <= value_ff);

   // next slot contents
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (place) begin
            value_in = left_place ? left_value : cmd.value;
         end
         valid_in = valid_ff | left_valid;
      end else if (cmd.pop) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   // valid bit is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stored value needs no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule : spl_cell
`default_nettype wire
